// File: sv/ralm_pkg.sv
// ----------------------------------------------------------------------------
// ralm_pkg
// types, constants and codes shared by the register ace lifetime monitor
// ----------------------------------------------------------------------------
`default_nettype none

package ralm_pkg;

   // default configuration of the monitor
   localparam int DEF_REGS_PER_CLASS = 128;
   localparam int DEF_NUM_CLASSES    = 3;
   localparam int DEF_TIME_WIDTH     = 48;

   // fixed widths of the result fields
   localparam int CYCLES_W = 48;
   localparam int TOTAL_W  = 64;
   localparam int LIVE_W   = 9;

   // event codes
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_CREAD  = 3'd3,
      CMD_ALLOC  = 3'd4,
      CMD_FREE   = 3'd5,
      CMD_BEGIN  = 3'd6,
      CMD_END    = 3'd7
   } ralm_cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2
   } ralm_state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] reg_class;
      logic [6:0] reg_index;
   } ralm_req_type;

   typedef struct packed {
      logic                window_active;
      logic [CYCLES_W-1:0] window_cycles;
      logic [TOTAL_W-1:0]  class_ace_total;
      logic [TOTAL_W-1:0]  class_commit_ace_total;
      logic [LIVE_W-1:0]   live_registers;
   } ralm_rsp_type;

   // per-entry lifetime flags
   typedef struct packed {
      logic cread;
      logic read;
      logic value;
   } ralm_flags_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic exec;
   } ralm_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } ralm_sts_type;

endpackage

`default_nettype wire

// File: sv/ralm_datapath.sv
// ----------------------------------------------------------------------------
// ralm_datapath
// entry memories, class totals, window state and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ralm_datapath #(
   parameter int REGS_PER_CLASS = ralm_pkg::DEF_REGS_PER_CLASS,
   parameter int NUM_CLASSES    = ralm_pkg::DEF_NUM_CLASSES,
   parameter int TIME_WIDTH     = ralm_pkg::DEF_TIME_WIDTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ralm_pkg::ralm_ctl_type ctl,
   output ralm_pkg::ralm_sts_type sts,
   input  ralm_pkg::ralm_req_type req_payload,
   input  wire                  csr_valid,
   input  wire                  csr_wdata,
   output ralm_pkg::ralm_rsp_type rsp_payload
);

   localparam int ENTRIES = NUM_CLASSES * REGS_PER_CLASS;
   localparam int AW      = $clog2(ENTRIES);
   localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int LCNT_W  = $clog2(ENTRIES + 1);

   // memories
   logic [TIME_WIDTH-1:0]   birth_mem [ENTRIES];
   logic [TIME_WIDTH-1:0]   lrd_mem   [ENTRIES];
   logic [TIME_WIDTH-1:0]   lcr_mem   [ENTRIES];
   ralm_pkg::ralm_flags_type flag_mem  [ENTRIES];

   logic [TIME_WIDTH-1:0]   rd_birth_ff, rd_lrd_ff, rd_lcr_ff;
   ralm_pkg::ralm_flags_type rd_flags_ff;

   // item and control state
   ralm_pkg::ralm_req_type  item_ff;
   logic [AW-1:0]           addr_ff;
   logic                    ent_ok_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic                    mode_ff;
   logic                    open_ff, open_in;
   logic [TIME_WIDTH-1:0]   cycle_ff, cycle_in;
   logic [LCNT_W-1:0]       live_ff, live_in;
   logic [ralm_pkg::TOTAL_W-1:0] ace_ff  [NUM_CLASSES];
   logic [ralm_pkg::TOTAL_W-1:0] cace_ff [NUM_CLASSES];
   logic [ralm_pkg::TOTAL_W-1:0] ace_in, cace_in;
   ralm_pkg::ralm_rsp_type  rsp_ff, rsp_in;

   // load side address
   logic                    req_ok;
   logic [AW-1:0]           req_addr;

   // exec side
   logic                    cls_ok;
   logic [CLS_W-1:0]        cls_sel;
   logic                    active;
   logic [TIME_WIDTH-1:0]   rd_from, cr_from, rd_diff, cr_diff;
   ralm_pkg::ralm_flags_type flags_in;
   logic                    flag_we, time_we, lrd_we, lcr_we;

   assign req_ok = (int'(req_payload.reg_class) < NUM_CLASSES)
                && (int'(req_payload.reg_index) < REGS_PER_CLASS);
   assign req_addr = req_ok ? AW'(int'(req_payload.reg_class) * REGS_PER_CLASS
                                  + int'(req_payload.reg_index)) : '0;

   assign sts.clear_last = (clr_cnt_ff == AW'(ENTRIES - 1));

   // item capture and registered memory read
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         item_ff     <= req_payload;
         addr_ff     <= req_addr;
         ent_ok_ff   <= req_ok;
         rd_birth_ff <= birth_mem[req_addr];
         rd_lrd_ff   <= lrd_mem[req_addr];
         rd_lcr_ff   <= lcr_mem[req_addr];
         rd_flags_ff <= flag_mem[req_addr];
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (ctl.exec && time_we) begin
         birth_mem[addr_ff] <= cycle_ff;
      end
      if (ctl.exec && lrd_we) begin
         lrd_mem[addr_ff] <= cycle_ff;
      end
      if (ctl.exec && lcr_we) begin
         lcr_mem[addr_ff] <= cycle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear_step) begin
         flag_mem[clr_cnt_ff] <= '0;
      end else if (ctl.exec && flag_we) begin
         flag_mem[addr_ff] <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctl.clear_step && !sts.clear_last) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign cls_ok  = (int'(item_ff.reg_class) < NUM_CLASSES);
   assign cls_sel = cls_ok ? item_ff.reg_class[CLS_W-1:0] : '0;
   assign active  = !mode_ff || open_ff;

   assign rd_from = rd_flags_ff.read  ? rd_lrd_ff : rd_birth_ff;
   assign cr_from = rd_flags_ff.cread ? rd_lcr_ff : rd_birth_ff;
   assign rd_diff = cycle_ff - rd_from;
   assign cr_diff = cycle_ff - cr_from;

   // event update
   always_comb begin
      cycle_in = cycle_ff;
      open_in  = open_ff;
      live_in  = live_ff;
      ace_in   = ace_ff[cls_sel];
      cace_in  = cace_ff[cls_sel];
      flags_in = rd_flags_ff;
      flag_we  = 1'b0;
      time_we  = 1'b0;
      lrd_we   = 1'b0;
      lcr_we   = 1'b0;
      unique case (item_ff.command) inside
         ralm_pkg::CMD_TICK: begin
            if (active && (cycle_ff != '1)) begin
               cycle_in = cycle_ff + TIME_WIDTH'(1);
            end
         end
         ralm_pkg::CMD_WRITE: begin
            if (ent_ok_ff && active) begin
               if (!rd_flags_ff.value) begin
                  live_in = live_ff + LCNT_W'(1);
               end
               time_we  = 1'b1;
               lrd_we   = 1'b1;
               lcr_we   = 1'b1;
               flag_we  = 1'b1;
               flags_in = '{cread: 1'b0, read: 1'b0, value: 1'b1};
            end
         end
         ralm_pkg::CMD_READ: begin
            if (ent_ok_ff && active && rd_flags_ff.value) begin
               ace_in        = ace_ff[cls_sel] + ralm_pkg::TOTAL_W'(rd_diff);
               flags_in.read = 1'b1;
               flag_we       = 1'b1;
               lrd_we        = 1'b1;
            end
         end
         ralm_pkg::CMD_CREAD: begin
            if (ent_ok_ff && active && rd_flags_ff.value) begin
               cace_in        = cace_ff[cls_sel] + ralm_pkg::TOTAL_W'(cr_diff);
               flags_in.cread = 1'b1;
               flag_we        = 1'b1;
               lcr_we         = 1'b1;
            end
         end
         ralm_pkg::CMD_ALLOC, ralm_pkg::CMD_FREE: begin
            if (ent_ok_ff) begin
               if (rd_flags_ff.value && (live_ff != '0)) begin
                  live_in = live_ff - LCNT_W'(1);
               end
               flags_in.value = 1'b0;
               if (item_ff.command == ralm_pkg::CMD_ALLOC) begin
                  flags_in.read = 1'b0;
               end
               flag_we = 1'b1;
            end
         end
         ralm_pkg::CMD_BEGIN: begin
            if (mode_ff) begin
               open_in = 1'b1;
            end
         end
         ralm_pkg::CMD_END: begin
            if (mode_ff) begin
               open_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.window_active          = !mode_ff || open_in;
      rsp_in.window_cycles          = ralm_pkg::CYCLES_W'(cycle_in);
      rsp_in.class_ace_total        = cls_ok ? ace_in : '0;
      rsp_in.class_commit_ace_total = cls_ok ? cace_in : '0;
      rsp_in.live_registers         = ralm_pkg::LIVE_W'(live_in);
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         open_ff  <= 1'b0;
         cycle_ff <= '0;
         live_ff  <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            ace_ff[c]  <= '0;
            cace_ff[c] <= '0;
         end
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_wdata;
         end
         if (ctl.exec) begin
            open_ff  <= open_in;
            cycle_ff <= cycle_in;
            live_ff  <= live_in;
            if (cls_ok) begin
               ace_ff[cls_sel]  <= ace_in;
               cace_ff[cls_sel] <= cace_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: sv/ralm_ctrl.sv
// ----------------------------------------------------------------------------
// ralm_ctrl
// sequencer: flag clearing sweep, item load, execute, result handshake
// ----------------------------------------------------------------------------
`default_nettype none

module ralm_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ralm_pkg::ralm_ctl_type ctl,
   input  ralm_pkg::ralm_sts_type sts
);

   ralm_pkg::ralm_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ralm_pkg::ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ralm_pkg::ST_IDLE;
            end
         end
         ralm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ralm_pkg::ST_EXEC;
            end
         end
         ralm_pkg::ST_EXEC: begin
            if (slot_free) begin
               state_in = ralm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ralm_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ralm_pkg::ST_CLEAR: begin
            ctl.clear_step = 1'b1;
         end
         ralm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         ralm_pkg::ST_EXEC: begin
            ctl.exec = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (ctl.exec) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ralm_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // an accepted beat always moves the sequencer to execute
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ralm_pkg::ST_EXEC))
      else $error("accepted beat not followed by execute");

   // never overwrite a result that is still waiting
   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // every execute produces a result beat
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> rsp_valid_ff)
      else $error("execute without result beat");

   // no beat taken during the flag sweep
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ralm_pkg::ST_CLEAR) |-> (req_stall && !ctl.load))
      else $error("beat accepted during flag clear");

endmodule

`default_nettype wire

// File: sv/register_ace_lifetime_monitor_unit.sv
// ----------------------------------------------------------------------------
// register_ace_lifetime_monitor_unit
// per-register ace lifetime tracking for several physical register classes
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  ralm_req_type (command, class, index)
// rsp      out        rsp_valid / rsp_stall  ralm_rsp_type (window, totals, live)
// csr      in         csr_valid / csr_ready  csr_wdata (window_mode)
//
// each beat is first captured and the entry memories read, then the entry
// and class totals are updated and the result register loaded
// after reset a sweep clears the flags of all NUM_CLASSES * REGS_PER_CLASS
// entries (384 by default), with req_stall high; csr writes are taken always
// a waiting result does not block capture of the next beat; the execute step
// holds until the result register is free
//
`default_nettype none

module register_ace_lifetime_monitor_unit #(
   parameter int REGS_PER_CLASS = ralm_pkg::DEF_REGS_PER_CLASS,
   parameter int NUM_CLASSES    = ralm_pkg::DEF_NUM_CLASSES,
   parameter int TIME_WIDTH     = ralm_pkg::DEF_TIME_WIDTH
) (
   input  wire                    clock,
   input  wire                    reset,
   // event input
   input  wire                    req_valid,
   output logic                   req_stall,
   input  ralm_pkg::ralm_req_type req_payload,
   // result output
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ralm_pkg::ralm_rsp_type rsp_payload,
   // window mode register
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire                    csr_wdata
);

   ralm_pkg::ralm_ctl_type ctl;
   ralm_pkg::ralm_sts_type sts;

   // mode register is always writable
   assign csr_ready = 1'b1;

   // sequencer
   ralm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .sts       (sts)
   );

   // memories, counters and totals
   ralm_datapath #(
      .REGS_PER_CLASS (REGS_PER_CLASS),
      .NUM_CLASSES    (NUM_CLASSES),
      .TIME_WIDTH     (TIME_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: bench/register_ace_lifetime_monitor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_ace_lifetime_monitor_unit_tb
// self-checking bench for the register ace lifetime monitor
// ----------------------------------------------------------------------------
//
// an initial block fills a backlog of events: a directed opening, a write to
// every physical register, then phases of register lifetimes (allocate,
// write, ticks, reads, commit reads, free) mixed with random noise events,
// alternating the window mode between always-open and marker-driven
// a clocked driver feeds the backlog into the req channel with random gaps,
// a clocked monitor tracks register lifetimes on every accepted beat and
// checks each rsp beat field by field against the oldest tracked report
// one phase holds rsp_stall for a long stretch so the block backs up
//
module register_ace_lifetime_monitor_unit_tb;

   localparam int REGS        = ralm_pkg::DEF_REGS_PER_CLASS;
   localparam int NUM_CLS     = ralm_pkg::DEF_NUM_CLASSES;
   localparam int NUM_ENTRIES = REGS * NUM_CLS;
   localparam int TIME_W      = ralm_pkg::DEF_TIME_WIDTH;

   // register class codes
   localparam int CLS_INT = 0;
   localparam int CLS_FP  = 1;
   localparam int CLS_VEC = 2;
   localparam int CLS_BAD = 3;

   localparam int          PHASES       = 6;
   localparam int          PHASE_EVENTS = 215;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          TAIL_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   ralm_pkg::ralm_req_type req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   ralm_pkg::ralm_rsp_type rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic                   csr_wdata   = 1'b0;

   register_ace_lifetime_monitor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // lifetime tracker state, mirrors the block's own bookkeeping
   // ------------------------------------------------------------------------
   logic                          life_mode   = 1'b0;
   logic                          life_open   = 1'b0;
   logic [TIME_W-1:0]             life_cycles = '0;
   logic [TIME_W-1:0]             life_birth      [NUM_ENTRIES];
   logic [TIME_W-1:0]             life_last_read  [NUM_ENTRIES];
   logic [TIME_W-1:0]             life_last_cread [NUM_ENTRIES];
   ralm_pkg::ralm_flags_type      life_flags [NUM_ENTRIES] = '{default: '0};
   logic [ralm_pkg::TOTAL_W-1:0]  life_ace   [NUM_CLS]     = '{default: '0};
   logic [ralm_pkg::TOTAL_W-1:0]  life_cace  [NUM_CLS]     = '{default: '0};
   int unsigned                   life_live   = 0;

   // reports of accepted events whose rsp beat has not arrived yet
   ralm_pkg::ralm_rsp_type lifetime_reports [$];
   ralm_pkg::ralm_rsp_type oldest_report;
   ralm_pkg::ralm_req_type event_backlog [$];

   int unsigned events_queued = 0;
   int unsigned events_taken  = 0;
   int unsigned mode_writes   = 0;
   int unsigned report_errors = 0;
   int unsigned run_cycles    = 0;

   // handshake bookkeeping shared between the edge processes
   bit          req_taken_now = 1'b0;
   bit          rsp_taken_now = 1'b0;
   bit          send_calm     = 1'b0;
   bit          take_calm     = 1'b0;
   int unsigned send_wait     = 0;
   int unsigned take_wait     = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;

   // apply one event to the tracked lifetimes and build the block's answer
   function automatic ralm_pkg::ralm_rsp_type track_lifetime(ralm_pkg::ralm_req_type ev);
      ralm_pkg::ralm_rsp_type rsp;
      logic                   ok;
      logic                   active;
      int unsigned            slot;
      logic [TIME_W-1:0]      now;
      logic [TIME_W-1:0]      from;
      logic [TIME_W-1:0]      span;
      ok     = (int'(ev.reg_class) < NUM_CLS) && (int'(ev.reg_index) < REGS);
      slot   = ok ? int'(ev.reg_class) * REGS + int'(ev.reg_index) : 0;
      now    = life_cycles;
      active = !life_mode || life_open;
      case (ev.command) inside
         ralm_pkg::CMD_TICK: begin
            // counts only inside the window, sticks at all ones
            if (active && life_cycles != '1)
               life_cycles = life_cycles + 1'b1;
         end
         ralm_pkg::CMD_WRITE: begin
            if (ok && active) begin
               if (!life_flags[slot].value)
                  life_live++;
               life_birth[slot]      = now;
               life_last_read[slot]  = now;
               life_last_cread[slot] = now;
               life_flags[slot]      = '{cread: 1'b0, read: 1'b0, value: 1'b1};
            end
         end
         ralm_pkg::CMD_READ: begin
            if (ok && active && life_flags[slot].value) begin
               from = life_flags[slot].read ? life_last_read[slot] : life_birth[slot];
               span = now - from;
               life_ace[ev.reg_class] = life_ace[ev.reg_class]
                                      + ralm_pkg::TOTAL_W'(span);
               life_flags[slot].read  = 1'b1;
               life_last_read[slot]   = now;
            end
         end
         ralm_pkg::CMD_CREAD: begin
            if (ok && active && life_flags[slot].value) begin
               from = life_flags[slot].cread ? life_last_cread[slot] : life_birth[slot];
               span = now - from;
               life_cace[ev.reg_class] = life_cace[ev.reg_class]
                                       + ralm_pkg::TOTAL_W'(span);
               life_flags[slot].cread  = 1'b1;
               life_last_cread[slot]   = now;
            end
         end
         ralm_pkg::CMD_ALLOC, ralm_pkg::CMD_FREE: begin
            // both end the value's life, allocate also forgets the read history
            if (ok) begin
               if (life_flags[slot].value && life_live > 0)
                  life_live--;
               life_flags[slot].value = 1'b0;
               if (ev.command == ralm_pkg::CMD_ALLOC)
                  life_flags[slot].read = 1'b0;
            end
         end
         ralm_pkg::CMD_BEGIN: begin
            if (life_mode)
               life_open = 1'b1;
         end
         default: begin
            if (life_mode)
               life_open = 1'b0;
         end
      endcase
      rsp.window_active = !life_mode || life_open;
      rsp.window_cycles = ralm_pkg::CYCLES_W'(life_cycles);
      if (int'(ev.reg_class) < NUM_CLS) begin
         rsp.class_ace_total        = life_ace[ev.reg_class];
         rsp.class_commit_ace_total = life_cace[ev.reg_class];
      end else begin
         rsp.class_ace_total        = '0;
         rsp.class_commit_ace_total = '0;
      end
      rsp.live_registers = ralm_pkg::LIVE_W'(life_live);
      return rsp;
   endfunction

   function automatic void note_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         report_errors++;
         if (report_errors <= 10)
            $display("%s mismatch: expected %0h, got %0h", field, want, got);
      end
   endfunction

   function automatic int unsigned pause_for(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // ------------------------------------------------------------------------
   // monitor: every handshake is judged on the values before the edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken_now = 1'b0;
      rsp_taken_now = 1'b0;
      if (!reset) begin
         // a result beat is checked before this edge's event is tracked
         if (rsp_valid && !rsp_stall) begin
            rsp_taken_now = 1'b1;
            if (lifetime_reports.size() == 0) begin
               report_errors++;
               if (report_errors <= 10)
                  $display("result beat with no event outstanding: %h", rsp_payload);
            end else begin
               oldest_report = lifetime_reports.pop_front();
               note_field("window_active", 64'(oldest_report.window_active),
                          64'(rsp_payload.window_active));
               note_field("window_cycles", 64'(oldest_report.window_cycles),
                          64'(rsp_payload.window_cycles));
               note_field("class_ace_total", oldest_report.class_ace_total,
                          rsp_payload.class_ace_total);
               note_field("class_commit_ace_total", oldest_report.class_commit_ace_total,
                          rsp_payload.class_commit_ace_total);
               note_field("live_registers", 64'(oldest_report.live_registers),
                          64'(rsp_payload.live_registers));
            end
         end
         if (req_valid && !req_stall) begin
            req_taken_now = 1'b1;
            lifetime_reports = {lifetime_reports, track_lifetime(req_payload)};
            events_taken++;
         end
         if (csr_valid && csr_ready) begin
            life_mode = csr_wdata;
            mode_writes++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver: a beat is held until taken, then the next one follows its gap
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!req_valid || req_taken_now) begin
         if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait--;
         end else if (event_backlog.size() != 0) begin
            req_payload <= event_backlog.pop_front();
            req_valid   <= 1'b1;
            send_wait   = pause_for(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here and only requested by the stimulus
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end
   end

   // receiver: a fresh wait is drawn after every result beat
   always @(negedge clock) begin
      if (rsp_taken_now)
         take_wait = pause_for(take_calm);
      if (take_wait != 0) begin
         rsp_stall <= 1'b1;
         take_wait--;
      end else begin
         rsp_stall <= (hold_left != 0);
      end
   end

   always @(posedge clock) begin
      run_cycles++;
      if (run_cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic void queue_event(ralm_pkg::ralm_cmd_type cmd, int unsigned cls,
                                       int unsigned idx);
      ralm_pkg::ralm_req_type ev;
      ev.command   = cmd;
      ev.reg_class = 2'(cls);
      ev.reg_index = 7'(idx);
      event_backlog = {event_backlog, ev};
      events_queued++;
   endfunction

   // any event, mostly on a small set of hot registers
   task automatic queue_noise();
      int unsigned            pick;
      int unsigned            cls;
      int unsigned            idx;
      ralm_pkg::ralm_cmd_type cmd;
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd = ralm_pkg::CMD_TICK;
      else if (pick < 45) cmd = ralm_pkg::CMD_WRITE;
      else if (pick < 62) cmd = ralm_pkg::CMD_READ;
      else if (pick < 75) cmd = ralm_pkg::CMD_CREAD;
      else if (pick < 82) cmd = ralm_pkg::CMD_ALLOC;
      else if (pick < 89) cmd = ralm_pkg::CMD_FREE;
      else if (pick < 96) cmd = ralm_pkg::CMD_BEGIN;
      else                cmd = ralm_pkg::CMD_END;
      cls = ($urandom_range(0, 19) == 0) ? CLS_BAD : $urandom_range(CLS_INT, CLS_VEC);
      idx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, REGS - 1) : $urandom_range(0, 7);
      queue_event(cmd, cls, idx);
   endtask

   // one register value, at times allocated first and freed at the end, with reads spread over ticks
   task automatic queue_lifetime(bit markers);
      int unsigned cls;
      int unsigned idx;
      cls = $urandom_range(CLS_INT, CLS_VEC);
      idx = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, REGS - 1);
      if (markers && $urandom_range(0, 4) != 0)
         queue_event(ralm_pkg::CMD_BEGIN, cls, idx);
      if ($urandom_range(0, 3) != 0)
         queue_event(ralm_pkg::CMD_ALLOC, cls, idx);
      queue_event(ralm_pkg::CMD_WRITE, cls, idx);
      repeat ($urandom_range(2, 9)) begin
         case ($urandom_range(0, 4))
            0, 1:    queue_event(ralm_pkg::CMD_TICK, $urandom_range(0, 3),
                                 $urandom_range(0, REGS - 1));
            2, 3:    queue_event(ralm_pkg::CMD_READ, cls, idx);
            default: queue_event(ralm_pkg::CMD_CREAD, cls, idx);
         endcase
      end
      if ($urandom_range(0, 1))
         queue_event(ralm_pkg::CMD_FREE, cls, idx);
      if (markers && $urandom_range(0, 4) == 0)
         queue_event(ralm_pkg::CMD_END, cls, idx);
   endtask

   // wait until every queued event has been taken and answered
   task automatic drain_events();
      do
         @(negedge clock);
      while (events_taken != events_queued || lifetime_reports.size() != 0);
   endtask

   // the block must be idle here, the write is taken at any time
   task automatic set_window_mode(logic mode);
      int unsigned seen;
      seen = mode_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do
         @(negedge clock);
      while (mode_writes == seen);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned phase;
      int unsigned mark;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window always open
      set_window_mode(1'b0);
      queue_event(ralm_pkg::CMD_TICK, CLS_BAD, REGS - 1);   // bad class still ticks
      queue_event(ralm_pkg::CMD_WRITE, CLS_INT, 0);
      queue_event(ralm_pkg::CMD_TICK, CLS_INT, 0);
      queue_event(ralm_pkg::CMD_TICK, CLS_INT, 0);
      queue_event(ralm_pkg::CMD_READ, CLS_INT, 0);          // measured from the write
      queue_event(ralm_pkg::CMD_TICK, CLS_INT, 0);
      queue_event(ralm_pkg::CMD_READ, CLS_INT, 0);          // measured from the last read
      queue_event(ralm_pkg::CMD_CREAD, CLS_INT, 0);         // commit side from the write
      queue_event(ralm_pkg::CMD_WRITE, CLS_VEC, REGS - 1);
      queue_event(ralm_pkg::CMD_WRITE, CLS_VEC, REGS - 1);  // overwrite, live count holds
      queue_event(ralm_pkg::CMD_TICK, CLS_FP, 64);
      queue_event(ralm_pkg::CMD_READ, CLS_VEC, REGS - 1);
      queue_event(ralm_pkg::CMD_ALLOC, CLS_INT, 0);
      queue_event(ralm_pkg::CMD_READ, CLS_INT, 0);          // no value left
      queue_event(ralm_pkg::CMD_FREE, CLS_VEC, REGS - 1);
      queue_event(ralm_pkg::CMD_CREAD, CLS_VEC, REGS - 1);
      queue_event(ralm_pkg::CMD_READ, CLS_BAD, 0);          // totals read as zero
      queue_event(ralm_pkg::CMD_BEGIN, CLS_FP, 0);          // markers ignored in this mode
      queue_event(ralm_pkg::CMD_END, CLS_FP, 0);
      drain_events();

      // give every register a value so later reads never hit unwritten times
      for (int cls = CLS_INT; cls <= CLS_VEC; cls++)
         for (int idx = 0; idx < REGS; idx++)
            queue_event(ralm_pkg::CMD_WRITE, cls, idx);
      drain_events();

      // marker-driven window, starts closed
      set_window_mode(1'b1);
      queue_event(ralm_pkg::CMD_TICK, CLS_INT, 3);          // closed, no count
      queue_event(ralm_pkg::CMD_WRITE, CLS_INT, 3);         // closed, no effect
      queue_event(ralm_pkg::CMD_READ, CLS_INT, 3);
      queue_event(ralm_pkg::CMD_END, CLS_INT, 3);           // end while closed
      queue_event(ralm_pkg::CMD_ALLOC, CLS_INT, 3);         // acts outside the window
      queue_event(ralm_pkg::CMD_BEGIN, CLS_INT, 3);
      queue_event(ralm_pkg::CMD_BEGIN, CLS_INT, 3);         // begin while open
      queue_event(ralm_pkg::CMD_WRITE, CLS_INT, 3);
      queue_event(ralm_pkg::CMD_TICK, CLS_INT, 3);
      queue_event(ralm_pkg::CMD_CREAD, CLS_INT, 3);
      queue_event(ralm_pkg::CMD_END, CLS_INT, 3);
      drain_events();

      for (phase = 0; phase < PHASES; phase++) begin
         set_window_mode(phase[0]);
         send_calm = (phase == 2) || ($urandom_range(0, 2) == 0);
         take_calm = (phase != 2) && ($urandom_range(0, 2) == 0);
         // back the block up: results held while events keep coming
         if (phase == 2)
            hold_requests++;
         mark = events_queued;
         while (events_queued - mark < PHASE_EVENTS) begin
            if ($urandom_range(0, 3) == 0)
               queue_noise();
            else
               queue_lifetime(phase[0]);
         end
         drain_events();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (report_errors == 0 && lifetime_reports.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
